// ===== rtl/csc_pkg.sv =====
// Shared types and constants for the cardinal spline coefficient stream.
// Used by csc_hermite and cardinal_spline_coeff_stream_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csc_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int TENSION_W       = 16;
	localparam logic [TENSION_W-1:0] TENSION_RESET = 16'd8192;  // 0.5 in Q2.14
	localparam int Q_SHIFT         = 14;
	localparam int SEG_W           = 16;
	localparam int A0_W            = 24;
	localparam int COEF_W          = 32;
	localparam int OUT_DATA_W      = SEG_W + 2 * A0_W + 6 * COEF_W;

	localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	// One axis of Hermite coefficients for one segment
	typedef struct packed {
		logic signed [A0_W-1:0]   a0;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
		logic signed [COEF_W-1:0] a3;
	} coef_t;

endpackage

`default_nettype wire

// ===== rtl/csc_hermite.sv =====
// Cubic Hermite coefficients of one axis from two points and two tangents.
// Depends on csc_pkg (coef_t, saturation limits).
`timescale 1ns / 1ps
`default_nettype none

module csc_hermite #(
	parameter int CW = csc_pkg::COORD_WIDTH_DEF,
	parameter int TW = CW + 4
) (
	input  logic signed [CW-1:0] pa,
	input  logic signed [CW-1:0] pb,
	input  logic signed [TW-1:0] ta,
	input  logic signed [TW-1:0] tb,
	output csc_pkg::coef_t       coef
);
	import csc_pkg::*;

	// Wide enough for 3*(pb-pa) - tb - 2*ta without overflow
	localparam int EW = (CW + 8 > COEF_W + 1) ? CW + 8 : COEF_W + 1;

	logic signed [EW-1:0] pa_e, pb_e, ta_e, tb_e, d_e, a2_e, a3_e;

	function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [EW-1:0] v);
		logic [EW-COEF_W:0] hi;
		hi = v[EW-1:COEF_W-1];
		if ((hi == '0) || (&hi))
			return v[COEF_W-1:0];
		return v[EW-1] ? COEF_MIN : COEF_MAX;
	endfunction

	assign pa_e = EW'(pa);
	assign pb_e = EW'(pb);
	assign ta_e = EW'(ta);
	assign tb_e = EW'(tb);
	assign d_e  = pb_e - pa_e;
	assign a2_e = (d_e <<< 1) + d_e - tb_e - (ta_e <<< 1);
	assign a3_e = ta_e + tb_e - (d_e <<< 1);

	assign coef.a0 = pa_e[A0_W-1:0];
	assign coef.a1 = sat_coef(ta_e);
	assign coef.a2 = sat_coef(a2_e);
	assign coef.a3 = sat_coef(a3_e);

endmodule

`default_nettype wire

// ===== rtl/cardinal_spline_coeff_stream_top.sv =====
// Top level of the cardinal spline coefficient stream.
// Depends on csc_pkg and csc_hermite.
//
// Usage:
//   s_* carries control points: tdata = {point_y, point_x} (point_x lowest),
//   tlast = end of polyline. m_* carries one Hermite segment per transfer,
//   tlast = final segment of the polyline. cfg_* writes the tension (Q2.14);
//   write it only while no point is in flight.
// Throughput: one point per cycle while m_tready stays high. A point with tlast
//   that closes a line of three or more points yields two segments and holds
//   stage 2 for its second segment, which backs up into s_tready.
// Pipeline: the point that completes a segment passes the difference stage,
//   the tension multiply stage and the coefficient add/saturate stage feeding
//   the output register.
// Reset: clears the pipeline, the polyline state and loads tension = 0.5.
// Receiver stall: the output register holds its segment; the two pipeline
//   stages keep filling, and s_tready drops only once both are occupied.
// A lone point with tlast gives no segment; a two-point line gives one.
`timescale 1ns / 1ps
`default_nettype none

module cardinal_spline_coeff_stream_top #(
	parameter int COORD_WIDTH = csc_pkg::COORD_WIDTH_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	// configuration write: tension
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [csc_pkg::TENSION_W-1:0]              cfg_data,
	// control points
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]         s_tdata,  // point_x, point_y, zero pad
	input  logic                                       s_tlast,  // end_of_line
	// segments
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	output logic [csc_pkg::OUT_DATA_W-1:0]             m_tdata,  // segment_index, a0_x, a0_y,
	                                                             // a1_x, a1_y, a2_x, a2_y,
	                                                             // a3_x, a3_y
	output logic                                       m_tlast   // final_segment
);
	import csc_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int DW = CW + 1;              // point difference
	localparam int PW = DW + TENSION_W + 1;  // difference times tension
	localparam int TW = PW - Q_SHIFT;        // tangent, full precision

	// points held for the current polyline
	localparam logic [1:0] PS_EMPTY = 2'd0;
	localparam logic [1:0] PS_ONE   = 2'd1;
	localparam logic [1:0] PS_TWO   = 2'd2;

	// what a point in flight emits
	localparam logic [1:0] MODE_PAIR = 2'd0;  // two-point line: one segment, zero tangents
	localparam logic [1:0] MODE_MID  = 2'd1;  // interior point: one segment
	localparam logic [1:0] MODE_LAST = 2'd2;  // closing point: two segments

	logic signed [CW-1:0] px, py;
	logic                 s_xfer;
	logic                 s1_load;

	// polyline state
	logic [TENSION_W-1:0] tension_q;
	logic [1:0]           ps_q;
	logic [SEG_W-1:0]     seg_cnt_q;
	logic signed [CW-1:0] older_x_q, older_y_q, newer_x_q, newer_y_q;
	logic signed [TW-1:0] pend_x_q, pend_y_q;

	// stage 1: differences ready for the multiply
	logic                 s1_v_q;
	logic [1:0]           mode_s1;
	logic [SEG_W-1:0]     idx_s1;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [CW-1:0] pa_x_s1, pa_y_s1, pb_x_s1, pb_y_s1, pc_x_s1, pc_y_s1;

	// stage 2: tangents ready for the coefficient adds
	logic                 s2_v_q, s2_phase_q;
	logic [1:0]           mode_s2;
	logic [SEG_W-1:0]     idx_s2;
	logic signed [CW-1:0] pa_x_s2, pa_y_s2, pb_x_s2, pb_y_s2, pc_x_s2, pc_y_s2;
	logic signed [TW-1:0] ta_x_s2, ta_y_s2, tb_x_s2, tb_y_s2;

	// output register
	logic                 out_v_q, out_last_q;
	logic [SEG_W-1:0]     out_idx_q;
	coef_t                out_x_q, out_y_q;

	logic                 out_free, s2_fire, s2_done, s2_free, s1_adv, s1_free;
	logic signed [PW-1:0] prod_x, prod_y;
	logic signed [TW-1:0] tan_x, tan_y;
	logic signed [CW-1:0] h_pa_x, h_pa_y, h_pb_x, h_pb_y;
	logic signed [TW-1:0] h_ta_x, h_ta_y, h_tb_x, h_tb_y;
	logic [SEG_W-1:0]     h_idx;
	logic                 h_last;
	coef_t                coef_x, coef_y;

	// ---------------------------------------------------------------- handshakes
	assign px     = s_tdata[CW-1:0];
	assign py     = s_tdata[2*CW-1:CW];
	assign s_xfer = s_tvalid && s_tready;
	// points that emit a segment: second point closing a line, or any later point
	assign s1_load = s_xfer && ((ps_q == PS_TWO) || ((ps_q == PS_ONE) && s_tlast));

	assign out_free = !out_v_q || m_tready;
	assign s2_fire  = s2_v_q && out_free;
	// a closing point leaves stage 2 only after its second segment
	assign s2_done  = s2_fire && ((mode_s2 != MODE_LAST) || s2_phase_q);
	assign s2_free  = !s2_v_q || s2_done;
	assign s1_adv   = s1_v_q && s2_free;
	assign s1_free  = !s1_v_q || s1_adv;
	assign s_tready = s1_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tension_q <= TENSION_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tension_q <= cfg_data;
		end
	end

	// ---------------------------------------------------------------- accept
	// Update the polyline state on every point transfer; hand points that
	// emit a segment to stage 1 with the difference for their tangent.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q      <= PS_EMPTY;
			seg_cnt_q <= '0;
			s1_v_q    <= 1'b0;
		end else begin
			s1_v_q <= s1_load || (s1_v_q && !s1_adv);
			if (s_xfer) begin
				unique case (ps_q)
					PS_EMPTY: begin
						if (!s_tlast)
							ps_q <= PS_ONE;
						seg_cnt_q <= '0;
					end
					PS_ONE: begin
						if (s_tlast) begin
							ps_q <= PS_EMPTY;
						end else begin
							ps_q <= PS_TWO;
						end
						seg_cnt_q <= '0;
					end
					PS_TWO: begin
						if (s_tlast) begin
							ps_q      <= PS_EMPTY;
							seg_cnt_q <= '0;
						end else if (seg_cnt_q != '1) begin
							seg_cnt_q <= seg_cnt_q + 1'b1;
						end
					end
					default: begin
						ps_q      <= PS_EMPTY;
						seg_cnt_q <= '0;
					end
				endcase
			end
		end
	end

	// stored points and stage 1 payload
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			newer_x_q <= px;
			newer_y_q <= py;
			older_x_q <= newer_x_q;
			older_y_q <= newer_y_q;
			idx_s1    <= seg_cnt_q;
			pc_x_s1   <= px;
			pc_y_s1   <= py;
			if (ps_q == PS_TWO) begin
				mode_s1 <= s_tlast ? MODE_LAST : MODE_MID;
				pa_x_s1 <= older_x_q;
				pa_y_s1 <= older_y_q;
				pb_x_s1 <= newer_x_q;
				pb_y_s1 <= newer_y_q;
				dx_s1   <= DW'(px) - DW'(older_x_q);
				dy_s1   <= DW'(py) - DW'(older_y_q);
			end else begin
				// two-point line: a zero difference gives the zero end tangent
				mode_s1 <= MODE_PAIR;
				pa_x_s1 <= newer_x_q;
				pa_y_s1 <= newer_y_q;
				pb_x_s1 <= px;
				pb_y_s1 <= py;
				dx_s1   <= '0;
				dy_s1   <= '0;
			end
		end
	end

	// ---------------------------------------------------------------- stage 1
	// Scale by tension; the part-select is the arithmetic shift by Q_SHIFT.
	assign prod_x = dx_s1 * $signed({1'b0, tension_q});
	assign prod_y = dy_s1 * $signed({1'b0, tension_q});
	assign tan_x  = prod_x[PW-1:Q_SHIFT];
	assign tan_y  = prod_y[PW-1:Q_SHIFT];

	// Pending tangent: the end tangent of the last interior segment, dropped
	// at line end so the next line starts from zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_x_q <= '0;
			pend_y_q <= '0;
		end else if (s1_adv) begin
			pend_x_q <= (mode_s1 == MODE_MID) ? tan_x : '0;
			pend_y_q <= (mode_s1 == MODE_MID) ? tan_y : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q     <= 1'b0;
			s2_phase_q <= 1'b0;
		end else begin
			if (s1_adv)
				s2_v_q <= 1'b1;
			else if (s2_done)
				s2_v_q <= 1'b0;
			if (s2_fire)
				s2_phase_q <= (mode_s2 == MODE_LAST) && !s2_phase_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			mode_s2 <= mode_s1;
			idx_s2  <= idx_s1;
			pa_x_s2 <= pa_x_s1;
			pa_y_s2 <= pa_y_s1;
			pb_x_s2 <= pb_x_s1;
			pb_y_s2 <= pb_y_s1;
			pc_x_s2 <= pc_x_s1;
			pc_y_s2 <= pc_y_s1;
			ta_x_s2 <= pend_x_q;
			ta_y_s2 <= pend_y_q;
			tb_x_s2 <= tan_x;
			tb_y_s2 <= tan_y;
		end
	end

	// ---------------------------------------------------------------- stage 2
	// First segment runs older->newer (first->second point on a two-point line); the
	// second segment of a closing point runs newer->last with a zero end tangent.
	always_comb begin
		if (s2_phase_q) begin
			h_pa_x = pb_x_s2;
			h_pa_y = pb_y_s2;
			h_pb_x = pc_x_s2;
			h_pb_y = pc_y_s2;
			h_ta_x = tb_x_s2;
			h_ta_y = tb_y_s2;
			h_tb_x = '0;
			h_tb_y = '0;
			h_idx  = (idx_s2 == '1) ? idx_s2 : idx_s2 + 1'b1;
			h_last = 1'b1;
		end else begin
			h_pa_x = pa_x_s2;
			h_pa_y = pa_y_s2;
			h_pb_x = pb_x_s2;
			h_pb_y = pb_y_s2;
			h_ta_x = ta_x_s2;
			h_ta_y = ta_y_s2;
			h_tb_x = tb_x_s2;
			h_tb_y = tb_y_s2;
			h_idx  = idx_s2;
			h_last = (mode_s2 == MODE_PAIR);
		end
	end

	csc_hermite #(.CW(CW), .TW(TW)) u_herm_x (
		.pa   (h_pa_x),
		.pb   (h_pb_x),
		.ta   (h_ta_x),
		.tb   (h_tb_x),
		.coef (coef_x)
	);

	csc_hermite #(.CW(CW), .TW(TW)) u_herm_y (
		.pa   (h_pa_y),
		.pb   (h_pb_y),
		.ta   (h_ta_y),
		.tb   (h_tb_y),
		.coef (coef_y)
	);

	// ---------------------------------------------------------------- output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s2_fire) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_fire) begin
			out_idx_q  <= h_idx;
			out_last_q <= h_last;
			out_x_q    <= coef_x;
			out_y_q    <= coef_y;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {out_y_q.a3, out_x_q.a3, out_y_q.a2, out_x_q.a2,
	                   out_y_q.a1, out_x_q.a1, out_y_q.a0, out_x_q.a0, out_idx_q};

	// ---------------------------------------------------------------- checks
	a_phase_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		s2_phase_q |-> (s2_v_q && (mode_s2 == MODE_LAST)))
		else $error("second segment phase outside a closing point");

	a_second_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_fire && s2_phase_q) |=> (m_tvalid && m_tlast))
		else $error("second segment of a closing point not marked final");

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ps_q != PS_TWO) |-> (seg_cnt_q == '0))
		else $error("segment counter running outside an open line");

	a_pend_clear: assert property (@(posedge clk) disable iff (!arst_n)
		((ps_q != PS_TWO) && !s1_v_q) |-> ((pend_x_q == '0) && (pend_y_q == '0)))
		else $error("pending tangent left over from a closed line");

endmodule

`default_nettype wire
